@@ rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked implication checks, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

@@ rtl/sfa_pkg.sv @@
// ----------------------------------------------------------------------------
// sfa_pkg
// Shared constants, types and tables of the spectrum frame averager.
// ----------------------------------------------------------------------------
`default_nettype none

package sfa_pkg;

    localparam int BINS_PER_HALF = 400;
    localparam int MAX_FRAMES    = 4;
    localparam int FRAME_BINS    = 2 * BINS_PER_HALF;
    localparam int RING          = (MAX_FRAMES > 1) ? MAX_FRAMES - 1 : 1;

    localparam int SAMPLE_W = 16;
    localparam int VAL_W    = 13;
    localparam int BIN_W    = $clog2(BINS_PER_HALF);
    localparam int ADDR_W   = $clog2(FRAME_BINS);
    localparam int SLOT_W   = (RING > 1) ? $clog2(RING) : 1;
    localparam int NW       = $clog2(MAX_FRAMES + 1);
    localparam int SUM_W    = $clog2(MAX_FRAMES * 4999 + 1);
    localparam int CUT_W    = 6;

    localparam logic [VAL_W-1:0] PEAK = VAL_W'(4999);

    localparam int NOTCH_FIRST = 265;
    localparam int NOTCH_A     = 266;
    localparam int NOTCH_B     = 267;
    localparam int NOTCH_HOLD  = 268;
    localparam int NOTCH_LAST  = 269;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SMOOTHING  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BAND_PASS  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MONITOR_TX = 2'd3;

    localparam logic [2:0] MODE_CW  = 3'd0;
    localparam logic [2:0] MODE_USB = 3'd1;
    localparam logic [2:0] MODE_LSB = 3'd2;
    localparam logic [2:0] MODE_AM  = 3'd3;

    localparam logic [CUT_W-1:0] CUT_TABLE [4] = '{6'd40, 6'd50, 6'd60, 6'd62};
    localparam logic [CUT_W-1:0] CUT_CW = 6'd2;

    // ceil(2^20 / n) for n = 1..8, exact truncating division for sums below 2^16
    localparam int RECIP_SHIFT = 20;
    localparam int RECIP_W     = 21;
    localparam logic [RECIP_W-1:0] RECIP [8] = '{
        21'd1048576, 21'd524288, 21'd349526, 21'd262144,
        21'd209716,  21'd174763, 21'd149797, 21'd131072
    };

    localparam int MAX_RESULTS = 4;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
    localparam int RES_IDX_W   = $clog2(MAX_RESULTS);

    typedef logic [RING-1:0][VAL_W-1:0] hist_word_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        hist_word_t        wr_data;
    } hist_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] value;
        logic [BIN_W-1:0] bin;
        logic             half;
        logic             last;
    } res_t;

    typedef struct packed {
        logic [RES_CNT_W-1:0]         count;
        res_t [MAX_RESULTS-1:0]       entries;
    } res_batch_t;

endpackage

`default_nettype wire

@@ rtl/sfa_if.sv @@
// ----------------------------------------------------------------------------
// sfa interfaces
// Valid/ready channels for bins, results and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface sfa_in_if;
    import sfa_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    logic                frame_start;
    modport source (output valid, output sample, output frame_start, input ready);
    modport sink   (input valid, input sample, input frame_start, output ready);
endinterface

interface sfa_out_if;
    import sfa_pkg::*;
    logic             valid;
    logic             ready;
    logic [VAL_W-1:0] value;
    logic [BIN_W-1:0] bin;
    logic             half;
    logic             last;
    modport source (output valid, output value, output bin, output half, output last,
                    input ready);
    modport sink   (input valid, input value, input bin, input half, input last,
                    output ready);
endinterface

interface sfa_cfg_if;
    import sfa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/sfa_history_mem.sv @@
// ----------------------------------------------------------------------------
// sfa_history_mem
// Frame history store, one row per bin holding every stored frame; clears
// itself row by row after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_history_mem (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire sfa_pkg::hist_req_t  req,
    output sfa_pkg::hist_word_t      rd_data,
    output logic                     clear_busy
);
    import sfa_pkg::*;

    hist_word_t        mem [FRAME_BINS];
    hist_word_t        rd_data_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              clearing_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
            clearing_reg <= 1'b1;
        end
        else if (clearing_reg)
        begin
            if (clr_addr_reg == ADDR_W'(FRAME_BINS - 1))
            begin
                clearing_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (clearing_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    assign rd_data    = rd_data_reg;
    assign clear_busy = clearing_reg;

endmodule

`default_nettype wire

@@ rtl/sfa_result_buf.sv @@
// ----------------------------------------------------------------------------
// sfa_result_buf
// Holds the results of one bin (up to four) and sends them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module sfa_result_buf (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                load,
    input  wire sfa_pkg::res_batch_t batch,
    output logic                     can_load,
    sfa_out_if.source                results
);
    import sfa_pkg::*;

    res_t [MAX_RESULTS-1:0] entries_reg;
    logic [RES_CNT_W-1:0]   rem_reg;
    logic [RES_IDX_W-1:0]   idx_reg;
    logic                   xfer;
    res_t                   cur;

    assign xfer     = results.valid && results.ready;
    assign can_load = (rem_reg == '0) || ((rem_reg == RES_CNT_W'(1)) && xfer);
    assign cur      = entries_reg[idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            rem_reg <= batch.count;
            idx_reg <= '0;
        end
        else if (xfer)
        begin
            rem_reg <= rem_reg - 1'b1;
            idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entries_reg <= batch.entries;
        end
    end

    assign results.valid = (rem_reg != '0);
    assign results.value = cur.value;
    assign results.bin   = cur.bin;
    assign results.half  = cur.half;
    assign results.last  = cur.last;

endmodule

`default_nettype wire

@@ rtl/spectrum_frame_averager_core.sv @@
// ----------------------------------------------------------------------------
// spectrum_frame_averager_core
// Per-bin moving average of spectrum frames with passband blanking and notch.
// ----------------------------------------------------------------------------
// Bins enter on samples (sample, frame_start); results leave on results
// (value, bin, half, last); cfg writes smoothing, mode, band_pass and
// monitor_tx by index and is always ready.
// For each accepted bin the history row is read at the transfer, summed in
// ST_SUM while the row is written back, then divided and queued in ST_DIV.
// The single read/modify/write of the history row per bin keeps new bins out
// until ST_DIV is left; the first result is valid the cycle after queueing.
// Bins 266..268 of the first half give no result of their own; bin 269
// releases four results, one per cycle while results is ready.
// After reset the history is cleared row by row, all 800 rows, while samples
// is not ready; configuration writes are taken throughout.
// When results stalls, the pending results hold; the next bin is still
// taken and processed, then waits until the queue has drained, and samples
// stays not ready meanwhile.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_frame_averager_core (
    input  wire logic clk,
    input  wire logic rst_n,
    sfa_in_if.sink    samples,
    sfa_out_if.source results,
    sfa_cfg_if.sink   cfg
);
    import sfa_pkg::*;
    `include "assert_macros.svh"

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SUM  = 3'b010,
        ST_DIV  = 3'b100
    } state_t;

    localparam int SW1 = SLOT_W + 1;

    state_t state_reg, state_next;

    logic [2:0]            smoothing_reg;
    logic [2:0]            mode_reg;
    logic [1:0]            band_pass_reg;
    logic                  monitor_tx_reg;

    logic [ADDR_W-1:0]     position_reg;
    logic [SLOT_W-1:0]     oldest_slot_reg;
    logic [CUT_W-1:0]      cut_low_reg, cut_high_reg;
    logic [CUT_W-1:0]      cut_low_next, cut_high_next;

    logic [ADDR_W-1:0]     p_reg;
    logic [VAL_W-1:0]      s_reg;
    logic [SLOT_W-1:0]     slot_reg;
    logic [NW-1:0]         n_reg;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [VAL_W-1:0]      held_reg [4];

    logic                  accept;
    logic [ADDR_W-1:0]     p_in;
    logic [SLOT_W-1:0]     slot_in;
    logic [ADDR_W:0]       pos_inc;
    logic [VAL_W-1:0]      s_in;
    logic [NW-1:0]         n_in;

    hist_req_t             hreq;
    hist_word_t            rd_word, wr_word;
    logic                  clear_busy;

    logic [SUM_W+RECIP_W-1:0] prod;
    logic [VAL_W-1:0]      avg;
    logic [VAL_W:0]        mean_sum;
    logic [VAL_W-1:0]      mean;
    logic                  half;
    logic [BIN_W-1:0]      bin;
    logic                  in_notch, is_269;
    res_batch_t            batch;
    logic                  can_load, load, leave_div;
    logic [2:0]            ri;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        return (s == SLOT_W'(RING - 1)) ? '0 : s + 1'b1;
    endfunction

    function automatic logic [SLOT_W-1:0] lane_of(input logic [SLOT_W-1:0] s, input int k);
        logic [SW1-1:0] t;
        t = {1'b0, s} + SW1'(RING - k);
        if (t >= SW1'(RING))
        begin
            t = t - SW1'(RING);
        end
        return t[SLOT_W-1:0];
    endfunction

    function automatic logic blanked(input logic [BIN_W-1:0] b, input logic h,
                                     input logic mon, input logic [CUT_W-1:0] lo,
                                     input logic [CUT_W-1:0] hi);
        logic r;
        if (!mon)
        begin
            r = 1'b0;
        end
        else if (!h)
        begin
            r = ({1'b0, b} + (BIN_W+1)'(lo)) < (BIN_W+1)'(BINS_PER_HALF);
        end
        else
        begin
            r = b >= BIN_W'(hi);
        end
        return r;
    endfunction

    function automatic res_t mk_res(input logic [VAL_W-1:0] v, input logic [BIN_W-1:0] b,
                                    input logic h);
        res_t r;
        r.value = v;
        r.bin   = b;
        r.half  = h;
        r.last  = (b == BIN_W'(BINS_PER_HALF - 1));
        return r;
    endfunction

    // configuration
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            smoothing_reg  <= 3'd1;
            mode_reg       <= MODE_CW;
            band_pass_reg  <= '0;
            monitor_tx_reg <= 1'b0;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_SMOOTHING:  smoothing_reg  <= cfg.data;
                CFG_MODE:       mode_reg       <= cfg.data;
                CFG_BAND_PASS:  band_pass_reg  <= cfg.data[1:0];
                CFG_MONITOR_TX: monitor_tx_reg <= cfg.data[0];
                default:        ;
            endcase
        end
    end

    // bin position, slot and cuts at the transfer
    assign accept        = samples.valid && samples.ready;
    assign samples.ready = (state_reg == ST_IDLE) && !clear_busy;

    always_comb
    begin
        p_in    = samples.frame_start ? '0 : position_reg;
        if ({1'b0, p_in} >= (ADDR_W+1)'(FRAME_BINS))
        begin
            p_in = '0;
        end
        slot_in = (samples.frame_start && (position_reg != '0)) ?
                  slot_inc(oldest_slot_reg) : oldest_slot_reg;
        pos_inc = {1'b0, p_in} + 1'b1;
        s_in    = (samples.sample > SAMPLE_W'(PEAK)) ? PEAK : samples.sample[VAL_W-1:0];

        if (smoothing_reg == '0)
        begin
            n_in = NW'(1);
        end
        else if ({1'b0, smoothing_reg} > 4'(MAX_FRAMES))
        begin
            n_in = NW'(MAX_FRAMES);
        end
        else
        begin
            n_in = NW'(smoothing_reg);
        end

        cut_low_next  = cut_low_reg;
        cut_high_next = cut_high_reg;
        case (mode_reg)
            MODE_CW:
            begin
                cut_low_next  = CUT_CW;
                cut_high_next = CUT_CW;
            end
            MODE_USB:
            begin
                cut_low_next  = '0;
                cut_high_next = CUT_TABLE[band_pass_reg];
            end
            MODE_LSB:
            begin
                cut_low_next  = CUT_TABLE[band_pass_reg];
                cut_high_next = '0;
            end
            MODE_AM:
            begin
                cut_low_next  = CUT_TABLE[band_pass_reg];
                cut_high_next = CUT_TABLE[band_pass_reg];
            end
            default: ;
        endcase
    end

    // history access
    always_comb
    begin
        wr_word           = rd_word;
        wr_word[slot_reg] = s_reg;
        hreq.rd_en        = accept;
        hreq.rd_addr      = p_in;
        hreq.wr_en        = (state_reg == ST_SUM);
        hreq.wr_addr      = p_reg;
        hreq.wr_data      = wr_word;
    end

    sfa_history_mem u_hist (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (hreq),
        .rd_data    (rd_word),
        .clear_busy (clear_busy)
    );

    always_comb
    begin
        sum_next = SUM_W'(s_reg);
        for (int k = 1; k < MAX_FRAMES; k++)
        begin
            if (k < int'(n_reg))
            begin
                sum_next = sum_next + SUM_W'(rd_word[lane_of(slot_reg, k)]);
            end
        end
    end

    // divide, blank and notch
    always_comb
    begin
        ri       = 3'(n_reg - 1'b1);
        prod     = (SUM_W+RECIP_W)'(sum_reg) * (SUM_W+RECIP_W)'(RECIP[ri]);
        avg      = prod[RECIP_SHIFT +: VAL_W];
        mean_sum = {1'b0, held_reg[0]} + {1'b0, avg};
        mean     = mean_sum[VAL_W:1];

        half = ({1'b0, p_reg} >= (ADDR_W+1)'(BINS_PER_HALF));
        bin  = half ? BIN_W'(p_reg - ADDR_W'(BINS_PER_HALF)) : BIN_W'(p_reg);

        in_notch = !half && (bin >= BIN_W'(NOTCH_FIRST)) && (bin <= BIN_W'(NOTCH_HOLD));
        is_269   = !half && (bin == BIN_W'(NOTCH_LAST));

        batch = '0;
        if (is_269)
        begin
            batch.count = RES_CNT_W'(4);
            batch.entries[0] = mk_res(
                blanked(BIN_W'(NOTCH_A), 1'b0, monitor_tx_reg, cut_low_reg, cut_high_reg) ?
                '0 : (monitor_tx_reg ? held_reg[1] : mean), BIN_W'(NOTCH_A), 1'b0);
            batch.entries[1] = mk_res(
                blanked(BIN_W'(NOTCH_B), 1'b0, monitor_tx_reg, cut_low_reg, cut_high_reg) ?
                '0 : (monitor_tx_reg ? held_reg[2] : mean), BIN_W'(NOTCH_B), 1'b0);
            batch.entries[2] = mk_res(
                blanked(BIN_W'(NOTCH_HOLD), 1'b0, monitor_tx_reg, cut_low_reg, cut_high_reg) ?
                '0 : held_reg[3], BIN_W'(NOTCH_HOLD), 1'b0);
            batch.entries[3] = mk_res(
                blanked(bin, 1'b0, monitor_tx_reg, cut_low_reg, cut_high_reg) ? '0 : avg,
                bin, 1'b0);
        end
        else if (!in_notch || (bin == BIN_W'(NOTCH_FIRST)))
        begin
            batch.count = RES_CNT_W'(1);
            batch.entries[0] = mk_res(
                blanked(bin, half, monitor_tx_reg, cut_low_reg, cut_high_reg) ? '0 : avg,
                bin, half);
        end

        leave_div = (state_reg == ST_DIV) && ((batch.count == '0) || can_load);
        load      = leave_div && (batch.count != '0);
    end

    sfa_result_buf u_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (load),
        .batch    (batch),
        .can_load (can_load),
        .results  (results)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (accept) state_next = ST_SUM;
            ST_SUM:  state_next = ST_DIV;
            ST_DIV:  if (leave_div) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            position_reg    <= '0;
            oldest_slot_reg <= '0;
            cut_low_reg     <= '0;
            cut_high_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                cut_low_reg  <= cut_low_next;
                cut_high_reg <= cut_high_next;
                if (pos_inc == (ADDR_W+1)'(FRAME_BINS))
                begin
                    position_reg    <= '0;
                    oldest_slot_reg <= slot_inc(slot_in);
                end
                else
                begin
                    position_reg    <= pos_inc[ADDR_W-1:0];
                    oldest_slot_reg <= slot_in;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_reg    <= p_in;
            s_reg    <= s_in;
            slot_reg <= slot_in;
            n_reg    <= n_in;
        end
        if (state_reg == ST_SUM)
        begin
            sum_reg <= sum_next;
        end
        if (leave_div && in_notch)
        begin
            held_reg[2'(bin - BIN_W'(NOTCH_FIRST))] <= avg;
        end
    end

    `ASSERT_NEXT(a_transfer_to_sum, accept, state_reg == ST_SUM)
    `ASSERT_IMPLIES(a_load_when_free, load, can_load)
    `ASSERT_IMPLIES(a_value_in_range, results.valid, results.value <= PEAK)

endmodule

`default_nettype wire

@@ sim/tb_spectrum_frame_averager_core.sv @@
// ----------------------------------------------------------------------------
// tb_spectrum_frame_averager_core
// Self-checking bench for the spectrum frame averager. Streams frames of bins
// (short, early-terminated, continued and one reaching notch bin 269) under a
// range of smoothing, mode, passband and monitor settings. A scoreboard
// predicts every result from its own copy of the per-bin history, cuts and
// notch hold-back, and compares each transfer on the results channel field by
// field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_spectrum_frame_averager_core;
    timeunit 1ns;
    timeprecision 1ps;

    import sfa_pkg::*;

    localparam logic [2:0]  MODE_OTHER  = 3'd4;
    localparam logic [2:0]  MODE_SPARE  = 3'd7;
    localparam int unsigned CYCLE_LIMIT = 100_000;
    localparam int          MAX_REPORTS = 30;

    class averager_scoreboard;
        bit [VAL_W-1:0] history [RING][FRAME_BINS];
        bit [VAL_W-1:0] held [4];
        int unsigned    next_pos;
        int unsigned    oldest;
        int unsigned    cut_lo;
        int unsigned    cut_hi;
        bit [2:0]       smoothing;
        bit [2:0]       mode;
        bit [1:0]       band_pass;
        bit             monitor_tx;
        res_t           expected_bins [$];
        int             errors;

        function new();
            next_pos   = 0;
            oldest     = 0;
            cut_lo     = 0;
            cut_hi     = 0;
            smoothing  = 3'd1;
            mode       = MODE_CW;
            band_pass  = 2'd0;
            monitor_tx = 1'b0;
            errors     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_SMOOTHING:  smoothing  = data;
                CFG_MODE:       mode       = data;
                CFG_BAND_PASS:  band_pass  = data[1:0];
                CFG_MONITOR_TX: monitor_tx = data[0];
                default: ;
            endcase
        endfunction

        function bit blanked(int unsigned bin_idx, bit hf);
            if (!monitor_tx)
                return 1'b0;
            if (!hf)
                return bin_idx < BINS_PER_HALF - cut_lo;
            return bin_idx >= cut_hi;
        endfunction

        function void expect_bin(int unsigned v, int unsigned bin_idx, bit hf);
            res_t r;
            r.value = VAL_W'(v);
            r.bin   = BIN_W'(bin_idx);
            r.half  = hf;
            r.last  = (bin_idx == BINS_PER_HALF - 1);
            expected_bins.push_back(r);
        endfunction

        function void note_bin(bit [SAMPLE_W-1:0] raw, bit fs);
            int unsigned p;
            int unsigned s;
            int unsigned n;
            int unsigned sum;
            int unsigned avg;
            int unsigned bin_idx;
            int unsigned mean;
            bit          hf;

            case (mode)
                MODE_CW:  begin cut_lo = CUT_CW;               cut_hi = CUT_CW;               end
                MODE_USB: begin cut_lo = 0;                    cut_hi = CUT_TABLE[band_pass]; end
                MODE_LSB: begin cut_lo = CUT_TABLE[band_pass]; cut_hi = 0;                    end
                MODE_AM:  begin cut_lo = CUT_TABLE[band_pass]; cut_hi = CUT_TABLE[band_pass]; end
                default: ;
            endcase

            if (fs) begin
                if (next_pos != 0)
                    oldest = (oldest + 1) % RING;
                p = 0;
            end
            else
                p = next_pos;
            if (p >= FRAME_BINS)
                p = 0;

            s = (raw > PEAK) ? PEAK : raw;
            n = smoothing;
            if (n < 1)
                n = 1;
            if (n > MAX_FRAMES)
                n = MAX_FRAMES;

            sum = s;
            for (int unsigned k = 1; k < n; k++)
                sum += history[(oldest + RING - k) % RING][p];
            avg = sum / n;
            history[oldest][p] = VAL_W'(s);

            hf      = (p >= BINS_PER_HALF);
            bin_idx = hf ? p - BINS_PER_HALF : p;

            next_pos = p + 1;
            if (next_pos >= FRAME_BINS) begin
                next_pos = 0;
                oldest   = (oldest + 1) % RING;
            end

            if (!hf && bin_idx >= NOTCH_FIRST && bin_idx <= NOTCH_HOLD) begin
                held[bin_idx - NOTCH_FIRST] = VAL_W'(avg);
                if (bin_idx == NOTCH_FIRST)
                    expect_bin(blanked(bin_idx, 1'b0) ? 0 : avg, bin_idx, 1'b0);
            end
            else if (!hf && bin_idx == NOTCH_LAST) begin
                mean = (held[0] + avg) / 2;
                for (int unsigned k = NOTCH_A; k <= NOTCH_B; k++) begin
                    if (blanked(k, 1'b0))
                        expect_bin(0, k, 1'b0);
                    else if (monitor_tx)
                        expect_bin(held[k - NOTCH_FIRST], k, 1'b0);
                    else
                        expect_bin(mean, k, 1'b0);
                end
                expect_bin(blanked(NOTCH_HOLD, 1'b0) ? 0 : held[3], NOTCH_HOLD, 1'b0);
                expect_bin(blanked(bin_idx, 1'b0) ? 0 : avg, bin_idx, 1'b0);
            end
            else
                expect_bin(blanked(bin_idx, hf) ? 0 : avg, bin_idx, hf);
        endfunction

        function void flag(string what, int unsigned want, int unsigned got);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d",
                         $time, what, want, got);
        endfunction

        function void check_result(res_t got);
            res_t want;
            if (expected_bins.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual bin %0d value %0d",
                             $time, got.bin, got.value);
                return;
            end
            want = expected_bins.pop_front();
            if (got.value !== want.value)
                flag("value", want.value, got.value);
            if (got.bin !== want.bin)
                flag("bin", want.bin, got.bin);
            if (got.half !== want.half)
                flag("half", want.half, got.half);
            if (got.last !== want.last)
                flag("last", want.last, got.last);
        endfunction
    endclass

    logic clk;
    logic rst_n;

    sfa_in_if  bins_ch ();
    sfa_out_if res_ch ();
    sfa_cfg_if cfg_ch ();

    averager_scoreboard sb;

    int          stall_style = 0;
    int          hold_reqs   = 0;
    bit          gaps_on     = 1'b0;
    int          burst_left  = 0;
    int unsigned cycles      = 0;

    spectrum_frame_averager_core u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .samples (bins_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk) begin
        res_t got;
        if (rst_n && res_ch.valid && res_ch.ready) begin
            got.value = res_ch.value;
            got.bin   = res_ch.bin;
            got.half  = res_ch.half;
            got.last  = res_ch.last;
            sb.check_result(got);
        end
    end

    initial begin
        int holds_done;
        int hold_left;
        int pat_cnt;
        holds_done   = 0;
        hold_left    = 0;
        pat_cnt      = 0;
        res_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_reqs != holds_done) begin
                holds_done = hold_reqs;
                hold_left  = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else begin
                pat_cnt++;
                case (stall_style)
                    0:       res_ch.ready <= 1'b1;
                    1:       res_ch.ready <= ($urandom_range(0, 99) >= 35);
                    default: res_ch.ready <= ((pat_cnt % 11) < 6);
                endcase
            end
        end
    end

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 4)
            return SAMPLE_W'($urandom_range(0, 65535));
        if (sel < 8)
            return SAMPLE_W'($urandom_range(0, 4999));
        return SAMPLE_W'($urandom_range(4990, 5010));
    endfunction

    task automatic send_bin(input logic [SAMPLE_W-1:0] raw, input logic fs);
        if (gaps_on && burst_left == 0) begin
            bins_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left--;
        bins_ch.valid       <= 1'b1;
        bins_ch.sample      <= raw;
        bins_ch.frame_start <= fs;
        do
            @(posedge clk);
        while (!bins_ch.ready);
        sb.note_bin(raw, fs);
        @(negedge clk);
    endtask

    task automatic pause_for_results();
        bins_ch.valid <= 1'b0;
        while (sb.expected_bins.size() != 0)
            @(negedge clk);
        repeat (12) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic load_config(input logic [2:0] sm, input logic [2:0] md,
                               input logic [2:0] bp, input logic [2:0] mt);
        write_reg(CFG_SMOOTHING, sm);
        write_reg(CFG_MODE, md);
        write_reg(CFG_BAND_PASS, bp);
        write_reg(CFG_MONITOR_TX, mt);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic send_frame(input int len, input logic fs0, input int retune_at);
        for (int i = 0; i < len; i++) begin
            if (i == retune_at) begin
                pause_for_results();
                load_config(sb.smoothing, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                            3'($urandom_range(0, 7)));
            end
            send_bin(pick_sample(), (i == 0) ? fs0 : 1'b0);
        end
    endtask

    initial begin
        int len;
        int retune;
        int fidx;

        sb                  = new();
        rst_n               = 1'b0;
        bins_ch.valid       = 1'b0;
        bins_ch.sample      = '0;
        bins_ch.frame_start = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = CFG_SMOOTHING;
        cfg_ch.data         = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_bin(16'd0, 1'b1);
        send_bin(16'hFFFF, 1'b0);
        send_bin(16'd4999, 1'b0);
        send_bin(16'd5000, 1'b0);
        send_bin(16'd4998, 1'b0);
        send_bin(16'd1, 1'b0);
        send_bin(16'hAAAA, 1'b0);
        send_bin(16'h5555, 1'b0);
        pause_for_results();
        load_config(3'd4, MODE_CW, 3'd0, 3'd0);
        for (int i = 0; i < 16; i++)
            send_bin((i < 8) ? 16'd4999 : 16'hFFFF, (i % 4) == 0);

        for (int ph = 0; ph < 9; ph++) begin
            pause_for_results();
            case (ph)
                0:       load_config(3'd1, MODE_CW, 3'd0, 3'd0);
                1:       load_config(3'd4, MODE_USB, 3'd3, 3'd1);
                2:       load_config(3'd0, MODE_LSB, 3'd4, 3'd1);
                3:       load_config(3'd7, MODE_AM, 3'd2, 3'd2);
                4:       load_config(3'd2, MODE_OTHER, 3'd1, 3'd1);
                5:       load_config(3'd3, MODE_SPARE, 3'd6, 3'd0);
                default: load_config(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                                     3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
            endcase
            stall_style = ph % 3;
            gaps_on     = (ph % 4 != 0) && (ph != 3);
            if (ph == 3)
                hold_reqs++;
            for (int f = 0; f < 2; f++) begin
                fidx = ph * 2 + f;
                if (fidx == 6)
                    len = NOTCH_LAST + 1;
                else
                    len = $urandom_range(1, 2);
                retune = (ph >= 2 && len > NOTCH_LAST && $urandom_range(0, 1)) ?
                         $urandom_range(NOTCH_A, NOTCH_LAST) : -1;
                send_frame(len, (fidx == 6) || ($urandom_range(0, 3) != 0), retune);
            end
        end

        pause_for_results();
        repeat (20) @(posedge clk);
        if (sb.errors == 0 && sb.expected_bins.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire

@@ filelist.f @@
+incdir+rtl
rtl/sfa_pkg.sv
rtl/sfa_if.sv
rtl/sfa_history_mem.sv
rtl/sfa_result_buf.sv
rtl/spectrum_frame_averager_core.sv
sim/tb_spectrum_frame_averager_core.sv
